[rtl/bcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bcp_pkg;

  localparam int ChargeMargin = 100;
  localparam int PercentFull  = 10000;
  localparam int PresetLimit  = 60000;

  localparam int NumW       = 30;
  localparam int DenW       = 17;
  localparam int QuoW       = 14;
  localparam int DivStages  = QuoW;
  localparam int CdivStages = 16;
  localparam int CfgIdxW    = 8;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CHG_HIGH   = 8'd0,
    REG_CHG_LOW    = 8'd1,
    REG_VOLT_FULL  = 8'd2,
    REG_VOLT_EMPTY = 8'd3
  } bcp_reg_e;

  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_FULL = 2'd1,
    MODE_DIV  = 2'd2
  } bcp_mode_e;

  typedef struct packed {
    logic        op;
    logic [15:0] charge_code;
    logic [15:0] voltage_code;
  } bcp_in_t;

  typedef struct packed {
    logic [13:0] percent_hundredths;
    logic [15:0] preset_charge;
  } bcp_out_t;

  typedef struct packed {
    logic [15:0] chg_high;
    logic [15:0] chg_low;
    logic [15:0] volt_full;
    logic [15:0] volt_empty;
  } bcp_cfg_t;

  typedef struct packed {
    logic            op;
    bcp_mode_e       mode;
    logic [NumW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } bcp_div_t;

  typedef struct packed {
    logic                  op;
    bcp_mode_e             mode;
    logic [NumW-1:0]       rem;
    logic [CdivStages-1:0] quo;
    logic [13:0]           pct;
  } bcp_scl_t;

endpackage
`default_nettype wire

[rtl/battery_charge_percent_and_preset_top.sv]
// Battery charge percent and preset charge.
// Input channel (in_valid_i/in_ready_o/in_data_i): one request per item; op 0
// turns a charge code into state of charge in 0.01 % units, op 1 turns a
// voltage code into a charge code to preset (at most 60000).
// Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result per
// request, in order; the field of the other op reads 0.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i): always
// ready; index 0 charge high, 1 charge low, 2 voltage full, 3 voltage empty,
// other indexes are dropped. Write only while no request is in flight.
// The pipeline is one prep stage, a 14-stage divider giving one quotient bit
// per stage, one multiply-add stage, a 16-stage divide by 10000 and the output
// register. Throughput is one request per cycle while the receiver does not stall.
// Reset empties the pipeline and loads the register defaults.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module battery_charge_percent_and_preset_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire bcp_pkg::bcp_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bcp_pkg::bcp_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [bcp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);

  bcp_pkg::bcp_cfg_t cfg_q;
  logic              en;
  logic              prep_valid, div_valid;
  bcp_pkg::bcp_div_t prep_data, div_data;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chg_high   <= 16'hFFFF;
      cfg_q.chg_low    <= 16'h0000;
      cfg_q.volt_full  <= 16'hFFFF;
      cfg_q.volt_empty <= 16'h0000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bcp_pkg::REG_CHG_HIGH:   cfg_q.chg_high   <= cfg_data_i;
        bcp_pkg::REG_CHG_LOW:    cfg_q.chg_low    <= cfg_data_i;
        bcp_pkg::REG_VOLT_FULL:  cfg_q.volt_full  <= cfg_data_i;
        bcp_pkg::REG_VOLT_EMPTY: cfg_q.volt_empty <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bcp_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (prep_valid),
    .data_o  (prep_data)
  );

  bcp_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .data_i  (prep_data),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  bcp_rescale u_rescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .data_i  (div_data),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTH
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.percent_hundredths <= 14'(bcp_pkg::PercentFull))
    else $error("percent above full scale");

  a_preset_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.preset_charge <= 16'(bcp_pkg::PresetLimit))
    else $error("preset above limit");

  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.percent_hundredths == '0 || out_data_o.preset_charge == '0))
    else $error("both result fields nonzero");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |=> $stable(div_valid) && $stable(prep_valid))
    else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

[rtl/bcp_prep.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_prep (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire bcp_pkg::bcp_in_t  data_i,
  input  wire bcp_pkg::bcp_cfg_t cfg_i,
  output logic                   valid_o,
  output bcp_pkg::bcp_div_t      data_o
);

  logic signed [17:0] hi_s, lo_s, span_s, c_s, diff_s;
  logic [15:0]        v_clamp;
  logic [15:0]        v_off;
  bcp_pkg::bcp_div_t  item_d, item_q;
  logic               valid_q;

  always_comb begin
    hi_s    = $signed({2'b00, cfg_i.chg_high}) - $signed(18'(bcp_pkg::ChargeMargin));
    lo_s    = $signed({2'b00, cfg_i.chg_low}) + $signed(18'(bcp_pkg::ChargeMargin));
    span_s  = hi_s - lo_s;
    c_s     = $signed({2'b00, data_i.charge_code});
    diff_s  = c_s - lo_s;
    v_clamp = data_i.voltage_code;
    if (v_clamp <= cfg_i.volt_empty) v_clamp = cfg_i.volt_empty;
    if (v_clamp >= cfg_i.volt_full) v_clamp = cfg_i.volt_full;
    v_off   = v_clamp - cfg_i.volt_empty;

    item_d      = '0;
    item_d.op   = data_i.op;
    item_d.mode = bcp_pkg::MODE_ZERO;
    if (!data_i.op) begin
      if (span_s <= 18'sd0) begin
        item_d.mode = bcp_pkg::MODE_ZERO;
      end else if (c_s >= hi_s) begin
        item_d.mode = bcp_pkg::MODE_FULL;
      end else if (c_s > lo_s) begin
        item_d.mode = bcp_pkg::MODE_DIV;
        item_d.rem  = 30'(diff_s[15:0]) * 30'(bcp_pkg::PercentFull);
        item_d.den  = span_s[16:0];
      end
    end else if (cfg_i.volt_full > cfg_i.volt_empty) begin
      item_d.mode = bcp_pkg::MODE_DIV;
      item_d.rem  = 30'(v_off) * 30'(bcp_pkg::PercentFull);
      item_d.den  = {1'b0, cfg_i.volt_full - cfg_i.volt_empty};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = item_q;

endmodule
`default_nettype wire

[rtl/bcp_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_divider (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire bcp_pkg::bcp_div_t data_i,
  output logic                   valid_o,
  output bcp_pkg::bcp_div_t      data_o
);

  bcp_pkg::bcp_div_t src   [bcp_pkg::DivStages+1];
  logic              v_src [bcp_pkg::DivStages+1];

  assign src[0]   = data_i;
  assign v_src[0] = valid_i;

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < bcp_pkg::DivStages; k++) begin : g_stage
    localparam int Bit = bcp_pkg::DivStages - 1 - k;
    bcp_pkg::bcp_div_t nxt, stage_q;
    logic [bcp_pkg::NumW:0] sub;
    logic               valid_q;

    always_comb begin
      nxt = src[k];
      sub = (bcp_pkg::NumW+1)'(src[k].den) << Bit;
      if ({1'b0, src[k].rem} >= sub) begin
        nxt.rem      = bcp_pkg::NumW'({1'b0, src[k].rem} - sub);
        nxt.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= v_src[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q <= nxt;
      end
    end

    assign src[k+1]   = stage_q;
    assign v_src[k+1] = valid_q;
  end

  assign valid_o = v_src[bcp_pkg::DivStages];
  assign data_o  = src[bcp_pkg::DivStages];

endmodule
`default_nettype wire

[rtl/bcp_rescale.sv]
`timescale 1ns / 1ps
`default_nettype none
module bcp_rescale (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire bcp_pkg::bcp_div_t data_i,
  input  wire bcp_pkg::bcp_cfg_t cfg_i,
  output logic                   valid_o,
  output bcp_pkg::bcp_out_t      data_o
);

  logic signed [17:0] thr_diff;
  logic signed [33:0] prod, num;
  bcp_pkg::bcp_scl_t  head_d;
  bcp_pkg::bcp_scl_t  src   [bcp_pkg::CdivStages+1];
  logic               v_src [bcp_pkg::CdivStages+1];
  logic               head_valid_q;
  bcp_pkg::bcp_scl_t  head_q;
  bcp_pkg::bcp_out_t  out_d, out_q;
  logic               out_valid_q;

  // preset numerator: low * 10000 + (high - low) * ratio, never negative
  always_comb begin
    thr_diff    = $signed({2'b00, cfg_i.chg_high}) - $signed({2'b00, cfg_i.chg_low});
    prod        = 34'(thr_diff) * $signed({20'd0, data_i.quo});
    num         = $signed({18'd0, cfg_i.chg_low}) * $signed(34'(bcp_pkg::PercentFull)) + prod;
    head_d      = '0;
    head_d.op   = data_i.op;
    head_d.mode = data_i.mode;
    head_d.rem  = num[bcp_pkg::NumW-1:0];
    unique case (data_i.mode)
      bcp_pkg::MODE_FULL: head_d.pct = 14'(bcp_pkg::PercentFull);
      bcp_pkg::MODE_DIV:  head_d.pct = data_i.quo;
      default:            head_d.pct = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
    end else if (en_i) begin
      head_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      head_q <= head_d;
    end
  end

  assign src[0]   = head_q;
  assign v_src[0] = head_valid_q;

  // divide by 10000, one quotient bit per stage
  for (genvar k = 0; k < bcp_pkg::CdivStages; k++) begin : g_stage
    localparam int Bit = bcp_pkg::CdivStages - 1 - k;
    localparam logic [bcp_pkg::NumW:0] Sub =
      (bcp_pkg::NumW+1)'(bcp_pkg::PercentFull) << Bit;
    bcp_pkg::bcp_scl_t nxt, stage_q;
    logic              valid_q;

    always_comb begin
      nxt = src[k];
      if ({1'b0, src[k].rem} >= Sub) begin
        nxt.rem      = bcp_pkg::NumW'({1'b0, src[k].rem} - Sub);
        nxt.quo[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q <= 1'b0;
      end else if (en_i) begin
        valid_q <= v_src[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q <= nxt;
      end
    end

    assign src[k+1]   = stage_q;
    assign v_src[k+1] = valid_q;
  end

  always_comb begin
    out_d = '0;
    if (!src[bcp_pkg::CdivStages].op) begin
      out_d.percent_hundredths = src[bcp_pkg::CdivStages].pct;
    end else if (src[bcp_pkg::CdivStages].mode == bcp_pkg::MODE_DIV) begin
      if (src[bcp_pkg::CdivStages].quo >= 16'(bcp_pkg::PresetLimit)) begin
        out_d.preset_charge = 16'(bcp_pkg::PresetLimit);
      end else begin
        out_d.preset_charge = src[bcp_pkg::CdivStages].quo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= v_src[bcp_pkg::CdivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
`default_nettype wire
